[src/crt_pkg.sv]
// ----------------------------------------------------------------------------
// crt_pkg
// Shared types and constants for the CRT reconstruction unit.
// ----------------------------------------------------------------------------
package crt_pkg;

  localparam int MaxPairs = 8;
  localparam int ModBits  = 16;
  localparam int IdxW     = $clog2(MaxPairs);
  localparam int CntW     = $clog2(MaxPairs + 1);
  localparam int DivW     = 34;   // dividend / divisor width of the shared divider
  localparam int DivCntW  = $clog2(DivW + 1);

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOTCOP   = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

  // datapath operations
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,        // store pair, update product
    OP_GCD_INIT,    // a = mod[i], b = mod[j]
    OP_GCD_STEP,    // start a % b
    OP_GCD_NEXT,    // a = b, b = remainder
    OP_PART_START,  // start M / m_i
    OP_INV_INIT,    // part captured, start part % m
    OP_EUC_INIT,    // r1 = m, r2 = part % m, t1 = 0, t2 = 1
    OP_EUC_DIV,     // start r1 / r2
    OP_EUC_NEXT,    // rotate Euclid registers (multiply by q)
    OP_COEF_MUL,    // prod = (res mod m) * inv ; start res % m first
    OP_COEF_DIV,    // start prod % m
    OP_ACC_MUL,     // prod = part * coef
    OP_ACC_DIV,     // start (acc + prod) % M
    OP_ACC_TAKE,    // acc = remainder
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [IdxW-1:0] idx_i;
    logic [IdxW-1:0] idx_j;
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic b_zero;     // gcd b operand is zero
    logic a_is_one;   // gcd result is one
    logic r2_zero;    // Euclid remainder is zero
    logic mod_zero;   // modulus i is zero
    logic mod_one;    // modulus i is one
    logic prod_big;   // product >= 2^32
  } dp_stat_t;

endpackage

[src/crt_divider.sv]
// ----------------------------------------------------------------------------
// crt_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module crt_divider (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      go,
  input  logic [crt_pkg::DivW-1:0]  dividend,
  input  logic [crt_pkg::DivW-1:0]  divisor,
  output logic                      busy,
  output logic [crt_pkg::DivW-1:0]  quotient,
  output logic [crt_pkg::DivW-1:0]  remainder
);
  import crt_pkg::*;

  logic [DivCntW-1:0] count;
  logic [DivW-1:0]    dvs;
  logic [DivW:0]      trial;
  logic [DivW:0]      shifted;

  assign shifted = {remainder, quotient[DivW-1]};
  assign trial   = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (go) begin
      busy      <= 1'b1;
      count     <= DivCntW'(DivW);
      quotient  <= dividend;
      remainder <= '0;
      dvs       <= divisor;
    end else if (busy) begin
      if (trial[DivW]) begin
        remainder <= shifted[DivW-1:0];
        quotient  <= {quotient[DivW-2:0], 1'b0};
      end else begin
        remainder <= trial[DivW-1:0];
        quotient  <= {quotient[DivW-2:0], 1'b1};
      end
      count <= count - 1'b1;
      if (count == DivCntW'(1)) busy <= 1'b0;
    end
  end

endmodule

[src/crt_datapath.sv]
// ----------------------------------------------------------------------------
// crt_datapath
// Pair stores, product, gcd and extended Euclid registers, accumulator.
// ----------------------------------------------------------------------------
module crt_datapath (
  input  logic             clk,
  input  logic             rst,
  input  crt_pkg::dp_cmd_t cmd,
  input  logic [15:0]      residue,
  input  logic [15:0]      modulus,
  output crt_pkg::dp_stat_t stat,
  output logic [31:0]      acc
);
  import crt_pkg::*;

  logic [15:0]       res_mem [MaxPairs];
  logic [ModBits-1:0] mod_mem [MaxPairs];
  logic [32:0]       product;
  logic [IdxW-1:0]   load_idx;
  logic [CntW-1:0]   load_cnt;

  logic [DivW-1:0]   ga, gb;
  logic [DivW-1:0]   part, coef, mul;
  logic signed [DivW:0] t1, t2;
  logic [DivW-1:0]   r1, r2;

  logic              div_go;
  logic [DivW-1:0]   div_n, div_d, div_q, div_r;
  logic              div_busy;
  logic [ModBits-1:0] mi;
  logic [31:0]       prod_mul;
  logic signed [33:0] qt;

  assign mi = mod_mem[cmd.idx_i];

  crt_divider u_div (
    .clk(clk), .rst(rst), .go(div_go), .dividend(div_n), .divisor(div_d),
    .busy(div_busy), .quotient(div_q), .remainder(div_r)
  );

  always_comb begin
    div_go = 1'b0;
    div_n  = '0;
    div_d  = DivW'(1);
    unique case (cmd.op)
      OP_GCD_STEP:   begin div_go = 1'b1; div_n = ga; div_d = gb; end
      OP_PART_START: begin div_go = 1'b1; div_n = DivW'(product); div_d = DivW'(mi); end
      OP_INV_INIT:   begin div_go = 1'b1; div_n = div_q; div_d = DivW'(mi); end
      OP_EUC_DIV:    begin div_go = 1'b1; div_n = r1; div_d = r2; end
      OP_COEF_MUL:   begin div_go = 1'b1; div_n = DivW'(res_mem[cmd.idx_i]);
                           div_d = DivW'(mi); end
      OP_COEF_DIV:   begin div_go = 1'b1; div_n = DivW'(prod_mul); div_d = DivW'(mi); end
      OP_ACC_DIV:    begin div_go = 1'b1; div_n = DivW'(acc) + mul;
                           div_d = DivW'(product); end
      default: ;
    endcase
  end

  // (res mod m) * inverse, both below the modulus
  assign prod_mul = div_r[15:0] * t1[15:0];
  // quotient and Euclid coefficient both fit in 17 signed bits
  assign qt = $signed({1'b0, div_q[15:0]}) * $signed(t2[16:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      load_cnt <= '0;
      product  <= 33'd1;
      acc      <= '0;
    end else begin
      unique case (cmd.op)
        OP_LOAD: begin
          if (load_cnt < CntW'(MaxPairs)) begin
            res_mem[load_idx] <= residue;
            mod_mem[load_idx] <= modulus[ModBits-1:0];
            load_cnt <= load_cnt + 1'b1;
            if (!product[32]) begin
              if (product * modulus[ModBits-1:0] > 49'h1_0000_0000)
                product <= 33'h1_0000_0000;
              else
                product <= 33'(product * modulus[ModBits-1:0]);
            end
          end
        end
        OP_GCD_INIT: begin
          ga <= DivW'(mod_mem[cmd.idx_i]);
          gb <= DivW'(mod_mem[cmd.idx_j]);
        end
        OP_GCD_NEXT: begin ga <= gb; gb <= div_r; end
        // start of accumulation for a new set
        OP_PART_START: if (cmd.idx_i == '0) acc <= '0;
        OP_INV_INIT: part <= div_q;
        OP_EUC_INIT: begin
          r1 <= DivW'(mi); r2 <= div_r; t1 <= '0; t2 <= (DivW+1)'(1);
        end
        OP_EUC_NEXT: begin
          r1 <= r2; r2 <= div_r; t1 <= t2;
          t2 <= t1 - (DivW+1)'(qt);
        end
        OP_COEF_MUL: begin
          // inverse fix-up; t1 holds last t before this op
          if (mi == ModBits'(1)) t1 <= '0;
          else if (t1 < 0) t1 <= t1 + $signed({1'b0, DivW'(mi)});
        end
        OP_ACC_MUL:  begin coef <= div_r; end
        OP_ACC_TAKE: acc <= div_r[31:0];
        OP_CLEAR: begin
          load_cnt <= '0;
          product  <= 33'd1;
        end
        default: ;
      endcase
    end
  end

  // multiply for accumulation registered in the cycle after coef capture
  logic acc_mul_d;
  always_ff @(posedge clk) begin
    if (rst) acc_mul_d <= 1'b0;
    else     acc_mul_d <= (cmd.op == OP_ACC_MUL);
  end

  always_ff @(posedge clk) begin
    if (acc_mul_d) mul <= DivW'(part[33:0] * coef[15:0]);
  end

  assign load_idx = load_cnt[IdxW-1:0];

  assign stat.div_busy = div_busy;
  assign stat.b_zero   = (gb == '0);
  assign stat.a_is_one = (ga == DivW'(1));
  assign stat.r2_zero  = (r2 == '0);
  assign stat.mod_zero = (mi == '0);
  assign stat.mod_one  = (mi == ModBits'(1));
  assign stat.prod_big = product[32];

endmodule

[src/crt_controller.sv]
// ----------------------------------------------------------------------------
// crt_controller
// Sequencer for loading, coprime check, inverses and accumulation.
// ----------------------------------------------------------------------------
module crt_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              last_pair,
  input  crt_pkg::dp_stat_t stat,
  output crt_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              done,
  output crt_pkg::status_t  status
);
  import crt_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ZCHK, S_GINIT, S_GTEST, S_GWAIT, S_GNEXT, S_GDONE, S_PCHK,
    S_PART, S_PWAIT, S_INV, S_IWAIT, S_EINIT, S_ETEST, S_EWAIT, S_ENEXT,
    S_CRES, S_CWAIT, S_CMUL, S_CDIV, S_CDWAIT, S_AMUL, S_AMUL2, S_ADIV,
    S_AWAIT, S_ATAKE, S_NEXTI, S_FINISH
  } state_t;

  state_t          state;
  logic [CntW-1:0] count;
  logic            overfull;
  logic [IdxW-1:0] i, j;
  status_t         result;

  always_comb begin
    cmd.idx_i = i;
    cmd.idx_j = j;
    cmd.op    = OP_NONE;
    unique case (state)
      S_IDLE:   if (start) cmd.op = OP_LOAD;
      S_GINIT:  cmd.op = OP_GCD_INIT;
      S_GTEST:  if (!stat.b_zero) cmd.op = OP_GCD_STEP;
      S_GNEXT:  cmd.op = OP_GCD_NEXT;
      S_PART:   cmd.op = OP_PART_START;
      S_INV:    cmd.op = OP_INV_INIT;
      S_EINIT:  cmd.op = OP_EUC_INIT;
      S_ETEST:  if (!stat.r2_zero) cmd.op = OP_EUC_DIV;
      S_ENEXT:  cmd.op = OP_EUC_NEXT;
      S_CRES:   cmd.op = OP_COEF_MUL;
      S_CMUL:   cmd.op = OP_COEF_DIV;
      S_AMUL:   cmd.op = OP_ACC_MUL;
      S_ADIV:   cmd.op = OP_ACC_DIV;
      S_ATAKE:  cmd.op = OP_ACC_TAKE;
      S_FINISH: cmd.op = OP_CLEAR;
      default:  ;
    endcase
  end

  assign busy = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      overfull <= 1'b0;
      done     <= 1'b0;
      status   <= ST_OK;
      result   <= ST_OK;
      i        <= '0;
      j        <= '0;
    end else begin
      done <= (state == S_FINISH);
      unique case (state)
        S_IDLE: if (start) begin
          if (count < CntW'(MaxPairs)) count <= count + 1'b1;
          else overfull <= 1'b1;
          if (last_pair) begin
            i      <= '0;
            result <= (overfull || count >= CntW'(MaxPairs)) ? ST_OVERFLOW : ST_OK;
            state  <= (overfull || count >= CntW'(MaxPairs)) ? S_FINISH : S_ZCHK;
          end
        end
        S_ZCHK: begin
          if (stat.mod_zero) begin
            result <= ST_NOTCOP; state <= S_FINISH;
          end else if (CntW'(i) + 1'b1 >= count) begin
            i <= '0; j <= IdxW'(1);
            state <= (count > CntW'(1)) ? S_GINIT : S_PCHK;
          end else i <= i + 1'b1;
        end
        S_GINIT: state <= S_GTEST;
        S_GTEST: state <= stat.b_zero ? S_GDONE : S_GWAIT;
        S_GWAIT: if (!stat.div_busy) state <= S_GNEXT;
        S_GNEXT: state <= S_GTEST;
        S_GDONE: begin
          if (!stat.a_is_one) begin
            result <= ST_NOTCOP; state <= S_FINISH;
          end else if (CntW'(j) + 1'b1 < count) begin
            j <= j + 1'b1; state <= S_GINIT;
          end else if (CntW'(i) + 2'd2 < count) begin
            i <= i + 1'b1; j <= i + 2'd2; state <= S_GINIT;
          end else begin
            i <= '0; state <= S_PCHK;
          end
        end
        S_PCHK: begin
          if (stat.prod_big) begin
            result <= ST_OVERFLOW; state <= S_FINISH;
          end else state <= S_PART;
        end
        S_PART:  state <= S_PWAIT;
        S_PWAIT: if (!stat.div_busy) state <= S_INV;
        S_INV:   state <= S_IWAIT;
        S_IWAIT: if (!stat.div_busy) state <= S_EINIT;
        S_EINIT: state <= S_ETEST;
        S_ETEST: state <= stat.r2_zero ? S_CRES : S_EWAIT;
        S_EWAIT: if (!stat.div_busy) state <= S_ENEXT;
        S_ENEXT: state <= S_ETEST;
        S_CRES:  state <= S_CWAIT;
        S_CWAIT: if (!stat.div_busy) state <= S_CMUL;
        S_CMUL:  state <= S_CDWAIT;
        S_CDWAIT: if (!stat.div_busy) state <= S_AMUL;
        S_AMUL:  state <= S_AMUL2;
        S_AMUL2: state <= S_ADIV;
        S_ADIV:  state <= S_AWAIT;
        S_AWAIT: if (!stat.div_busy) state <= S_ATAKE;
        S_ATAKE: state <= S_NEXTI;
        S_NEXTI: begin
          if (CntW'(i) + 1'b1 < count) begin
            i <= i + 1'b1; state <= S_PART;
          end else state <= S_FINISH;
        end
        S_FINISH: begin
          status   <= result;
          count    <= '0;
          overfull <= 1'b0;
          state    <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

[src/crt_reconstruct_unit.sv]
// ----------------------------------------------------------------------------
// crt_reconstruct_unit
// Chinese remainder reconstruction over up to eight 16-bit moduli.
// ----------------------------------------------------------------------------
// Operation: a pair without the last mark is stored and multiplied into the product.
//   After a last pair, each gcd step and each Euclid step costs one pass of the
//   shared bit-serial divider plus sequencing, and each pair five more divider
//   passes; a set with too many pairs goes straight to the overflow result.
// Throughput: one set at a time; start is taken only while busy is low.
// Reset: synchronous; clears the pair count, product, accumulator and sequencer.
module crt_reconstruct_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] residue,
  input  logic [15:0] modulus,
  input  logic        last_pair,
  output logic        done,
  output logic [31:0] solution,
  output logic [1:0]  status
);
  import crt_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  status_t     st;
  logic [31:0] acc;

  crt_controller u_ctrl (
    .clk(clk), .rst(rst), .start(start), .last_pair(last_pair), .stat(stat),
    .cmd(cmd), .busy(busy), .done(done), .status(st)
  );

  crt_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .residue(residue), .modulus(modulus),
    .stat(stat), .acc(acc)
  );

  assign status   = st;
  assign solution = (st == ST_OK) ? acc : 32'd0;

endmodule

[src/crt_checker.sv]
// ----------------------------------------------------------------------------
// crt_checker
// Port-level checks for the CRT reconstruction unit.
// ----------------------------------------------------------------------------
module crt_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        last_pair,
  input logic        done,
  input logic [31:0] solution,
  input logic [1:0]  status
);
  import crt_pkg::*;

  a_no_done_reset: assert property (@(posedge clk) rst |=> !done)
    else $error("done after reset");
  a_done_once: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held");
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_NOTCOP || status == ST_OVERFLOW))
    else $error("bad status");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> solution == 32'd0)
    else $error("solution on error");
  a_busy_last: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last_pair) |=> busy)
    else $error("not busy after last pair");
endmodule

bind crt_reconstruct_unit crt_checker u_chk (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .last_pair(last_pair),
  .done(done), .solution(solution), .status(status)
);
